### src/gic_pkg.sv
package gic_pkg;

  // Fixed field widths of the block
  localparam int LEN_W   = 15;
  localparam int COUNT_W = 7;

  // Input item kinds, carried on s_axis_tuser
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_SOLVE = 1'b1;

endpackage

### src/gic_ram.sv
module gic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/greedy_interval_cover.sv
// Greedy minimum cover of the range [0, cover_length] by integer segments.
// Input stream (s_axis): tuser is the item kind. A load item carries one
// segment in tdata; segments that cannot touch the range are dropped, and
// segments beyond MAX_SEGMENTS set the overflow flag.
// A solve item runs the greedy rounds and holds off the input until the last
// result is in the output register; s_axis_tready stays low meanwhile.
// Each round scans the segment memory once through its single read port and
// then decides. Each chosen segment is then read out through the index
// memory, the segment memory and the output register, in that order, and
// the next one starts only once the previous is in the output register.
// Output stream (m_axis): one item per chosen segment, tlast on the final one;
// a failed solve gives one item with covered = 0. The output register holds
// while m_axis_tready is low and the block waits; once the last item is in
// the register the store is cleared and the next input item is taken.
// cfg_we_i writes cover_length (reset value 1); write it only while idle.
// Reset clears the count, flags and state; memory contents are not cleared,
// only entries written since the last solve are ever read.
module greedy_interval_cover #(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                      cfg_we_i,
  input  logic [gic_pkg::LEN_W-1:0] cfg_data_i,

  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata: seg_left, seg_right
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata_i,
  // tuser: kind
  input  logic                                 s_axis_tuser_i,

  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // tdata: chosen_count, out_left, out_right
  output logic [((gic_pkg::COUNT_W+2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // tuser: covered, overflowed
  output logic [1:0]                           m_axis_tuser_o,
  // tlast: last
  output logic                                 m_axis_tlast_o
);

  localparam int IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int CMP_W  = ((COORD_BITS > gic_pkg::LEN_W) ? COORD_BITS : gic_pkg::LEN_W) + 1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_FAIL,
    ST_IDX,
    ST_SEG,
    ST_EMIT
  } state_e;

  state_e state_q;

  logic [gic_pkg::LEN_W-1:0] len_q;
  logic [CNT_W-1:0]          count_q;
  logic [CNT_W-1:0]          total_q;
  logic [CNT_W-1:0]          scan_cnt_q;
  logic                      data_vld_q;
  logic [IDX_W-1:0]          k_q;
  logic                      ovf_q;
  logic signed [COORD_BITS-1:0] pos_q;

  logic                         found_q;
  logic [IDX_W-1:0]             best_idx_q;
  logic signed [COORD_BITS-1:0] best_l_q;
  logic signed [COORD_BITS-1:0] best_r_q;

  logic                         out_valid_q;
  logic                         out_covered_q;
  logic [gic_pkg::COUNT_W-1:0]  out_count_q;
  logic signed [COORD_BITS-1:0] out_left_q;
  logic signed [COORD_BITS-1:0] out_right_q;
  logic                         out_ovf_q;
  logic                         out_last_q;

  // Input decode
  logic signed [COORD_BITS-1:0] in_l, in_r;
  logic signed [CMP_W-1:0]      in_l_ext, len_ext, best_r_ext;
  logic                         in_accept, in_keep, store_full;

  assign in_l       = $signed(s_axis_tdata_i[COORD_BITS-1:0]);
  assign in_r       = $signed(s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS]);
  assign in_l_ext   = CMP_W'(in_l);
  assign best_r_ext = CMP_W'(best_r_q);
  assign len_ext    = $signed({{(CMP_W-gic_pkg::LEN_W){1'b0}}, len_q});
  assign in_keep    = !in_r[COORD_BITS-1] && (in_l_ext <= len_ext);
  assign store_full = (count_q == CNT_W'(MAX_SEGMENTS));

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // Segment memory: left end low, right end high
  logic                      seg_we;
  logic [IDX_W-1:0]          seg_raddr;
  logic [2*COORD_BITS-1:0]   seg_rdata;
  logic signed [COORD_BITS-1:0] rd_l, rd_r;

  assign seg_we = in_accept && (s_axis_tuser_i == gic_pkg::KIND_LOAD) && in_keep && !store_full;
  assign rd_l   = $signed(seg_rdata[COORD_BITS-1:0]);
  assign rd_r   = $signed(seg_rdata[2*COORD_BITS-1:COORD_BITS]);

  // Chosen index memory
  logic              chs_we;
  logic [IDX_W-1:0]  chs_rdata;

  assign chs_we    = (state_q == ST_DECIDE) && found_q &&
                     ((total_q == '0) || (best_r_q > pos_q));
  assign seg_raddr = (state_q == ST_SCAN) ? scan_cnt_q[IDX_W-1:0] : chs_rdata;

  gic_ram #(
    .WIDTH (2*COORD_BITS),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i ({in_r, in_l}),
    .raddr_i (seg_raddr),
    .rdata_o (seg_rdata)
  );

  gic_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_chs_ram (
    .clk_i   (clk_i),
    .we_i    (chs_we),
    .waddr_i (total_q[IDX_W-1:0]),
    .wdata_i (best_idx_q),
    .raddr_i (k_q),
    .rdata_o (chs_rdata)
  );

  logic scan_issue, better, out_free, out_load;

  assign scan_issue = (scan_cnt_q < count_q);
  assign better     = (rd_l <= pos_q) &&
                      (!found_q || (rd_r > best_r_q) ||
                       ((rd_r == best_r_q) && (rd_l < best_l_q)));
  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign out_load   = ((state_q == ST_FAIL) || (state_q == ST_EMIT)) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_LOAD;
      len_q         <= gic_pkg::LEN_W'(1);
      count_q       <= '0;
      total_q       <= '0;
      scan_cnt_q    <= '0;
      data_vld_q    <= 1'b0;
      k_q           <= '0;
      ovf_q         <= 1'b0;
      pos_q         <= '0;
      found_q       <= 1'b0;
      best_idx_q    <= '0;
      best_l_q      <= '0;
      best_r_q      <= '0;
      out_valid_q   <= 1'b0;
      out_covered_q <= 1'b0;
      out_count_q   <= '0;
      out_left_q    <= '0;
      out_right_q   <= '0;
      out_ovf_q     <= 1'b0;
      out_last_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_LOAD: begin
          if (in_accept) begin
            if (s_axis_tuser_i == gic_pkg::KIND_SOLVE) begin
              pos_q      <= '0;
              total_q    <= '0;
              scan_cnt_q <= '0;
              data_vld_q <= 1'b0;
              found_q    <= 1'b0;
              state_q    <= (count_q == '0) ? ST_FAIL : ST_SCAN;
            end else if (in_keep) begin
              if (store_full) begin
                ovf_q <= 1'b1;
              end else begin
                count_q <= count_q + CNT_W'(1);
              end
            end
          end
        end

        ST_SCAN: begin
          // Issue one read a cycle, fold in the data of the previous read
          data_vld_q <= scan_issue;
          if (scan_issue) begin
            scan_cnt_q <= scan_cnt_q + CNT_W'(1);
          end
          if (data_vld_q && better) begin
            found_q    <= 1'b1;
            best_idx_q <= scan_cnt_q[IDX_W-1:0] - IDX_W'(1);
            best_l_q   <= rd_l;
            best_r_q   <= rd_r;
          end
          if (!scan_issue && !data_vld_q) begin
            state_q <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          if (!chs_we) begin
            state_q <= ST_FAIL;
          end else begin
            total_q <= total_q + CNT_W'(1);
            pos_q   <= best_r_q;
            if (best_r_ext >= len_ext) begin
              k_q     <= '0;
              state_q <= ST_IDX;
            end else if (total_q + CNT_W'(1) == CNT_W'(MAX_SEGMENTS)) begin
              state_q <= ST_FAIL;
            end else begin
              scan_cnt_q <= '0;
              data_vld_q <= 1'b0;
              found_q    <= 1'b0;
              state_q    <= ST_SCAN;
            end
          end
        end

        ST_FAIL: begin
          if (out_free) begin
            out_covered_q <= 1'b0;
            out_count_q   <= '0;
            out_left_q    <= '0;
            out_right_q   <= '0;
            out_ovf_q     <= ovf_q;
            out_last_q    <= 1'b1;
            count_q       <= '0;
            total_q       <= '0;
            pos_q         <= '0;
            ovf_q         <= 1'b0;
            state_q       <= ST_LOAD;
          end
        end

        ST_IDX: begin
          state_q <= ST_SEG;
        end

        ST_SEG: begin
          state_q <= ST_EMIT;
        end

        ST_EMIT: begin
          if (out_free) begin
            out_covered_q <= 1'b1;
            out_count_q   <= gic_pkg::COUNT_W'(total_q);
            out_left_q    <= rd_l;
            out_right_q   <= rd_r;
            out_ovf_q     <= ovf_q;
            if (CNT_W'(k_q) + CNT_W'(1) == total_q) begin
              out_last_q <= 1'b1;
              count_q    <= '0;
              total_q    <= '0;
              pos_q      <= '0;
              ovf_q      <= 1'b0;
              state_q    <= ST_LOAD;
            end else begin
              out_last_q <= 1'b0;
              k_q        <= k_q + IDX_W'(1);
              state_q    <= ST_IDX;
            end
          end
        end

        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[gic_pkg::COUNT_W-1:0]                 = out_count_q;
    m_axis_tdata_o[gic_pkg::COUNT_W +: COORD_BITS]       = out_left_q;
    m_axis_tdata_o[gic_pkg::COUNT_W+COORD_BITS +: COORD_BITS] = out_right_q;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = {out_ovf_q, out_covered_q};
  assign m_axis_tlast_o  = out_last_q;

  // A scan never starts on an empty store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (count_q != '0))
    else $error("scan on empty store");

  // Count and cover size stay within the memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CNT_W'(MAX_SEGMENTS)) && (total_q <= CNT_W'(MAX_SEGMENTS)))
    else $error("count beyond capacity");

  // A chosen segment lies within the stored entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chs_we |-> (CNT_W'(best_idx_q) < count_q))
    else $error("chosen index beyond store");

  // A loaded cover item always carries a non-zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free) |=> (out_valid_q && out_covered_q && out_count_q != '0))
    else $error("cover item without count");

endmodule
